### rtl/core/des_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// des_pkg
// permutation tables, s-boxes and helper functions of the des core
// ----------------------------------------------------------------------------
package des_pkg;

  localparam int NumRounds = 16;

  localparam logic [6:0] IP_TAB [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

  localparam logic [6:0] FP_TAB [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

  localparam logic [5:0] E_TAB [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

  localparam logic [5:0] P_TAB [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};

  localparam logic [6:0] PC1_TAB [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18, 10,2,59,51,43,35,27,
    19,11,3,60,52,44,36, 63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};

  localparam logic [5:0] PC2_TAB [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

  // cumulative left rotation of both key halves after each round
  localparam logic [4:0] ROT_CUM [NumRounds] = '{
    1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28};

  localparam logic [3:0] SBOX [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,7,6,0,8,13,1},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,5,6,3,11}};

  // register index of the key
  localparam logic REG_CIPHER_KEY = 1'b0;

  typedef logic [NumRounds-1:0][47:0] rkey_set_t;

  function automatic logic [63:0] des_ip(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(IP_TAB[i])];
    return r;
  endfunction

  function automatic logic [63:0] des_fp(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(FP_TAB[i])];
    return r;
  endfunction

  // e expansion, key mix, s-boxes and p permutation
  function automatic logic [31:0] des_f(input logic [31:0] h, input logic [47:0] k);
    logic [47:0] x;
    logic [5:0]  chunk;
    logic [31:0] s;
    logic [31:0] r;
    for (int i = 0; i < 48; i++) x[47-i] = h[32-int'(E_TAB[i])];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      chunk = x[47-6*i -: 6];
      s[31-4*i -: 4] = SBOX[i][{chunk[5], chunk[0], chunk[4:1]}];
    end
    for (int i = 0; i < 32; i++) r[31-i] = s[32-int'(P_TAB[i])];
    return r;
  endfunction

  // round key of round rnd (from 0); pure wiring for a constant round
  function automatic logic [47:0] des_round_key(input logic [63:0] key, input int rnd);
    logic [55:0] cd;
    logic [55:0] cc;
    logic [55:0] dd;
    logic [55:0] rot;
    logic [47:0] r;
    for (int i = 0; i < 56; i++) cd[55-i] = key[64-int'(PC1_TAB[i])];
    cc  = {cd[55:28], cd[55:28]};
    dd  = {cd[27:0], cd[27:0]};
    rot = {cc[55-int'(ROT_CUM[rnd]) -: 28], dd[55-int'(ROT_CUM[rnd]) -: 28]};
    for (int i = 0; i < 48; i++) r[47-i] = rot[56-int'(PC2_TAB[i])];
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/des_block_cipher_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// des_block_cipher_core
// fully unrolled des engine, an ip input stage then one feistel round per stage
// ----------------------------------------------------------------------------
// A 64-bit block and an encrypt/decrypt flag enter on the in_ stream; the
// result leaves on the out_ stream in request order. The pipeline takes one
// request per clock while in_tready is high: an input register applying IP,
// then sixteen round registers, each holding one Feistel round. The output
// bus shows the last round register through FP. Each stage has its own valid
// bit and moves whenever its successor is empty or moving, so bubbles are
// squeezed out and a back-pressured output does not block requests while
// empty stages remain. The key lives in the 64-bit register at addresses 0
// to 7 (paddr[3] clear) of the cfg_ port; round keys are fixed wiring from
// it (PC-1, rotations, PC-2), and decrypt requests pick them in reverse
// order inside each stage. Write the key only while the pipeline is empty.
// ----------------------------------------------------------------------------
module des_block_cipher_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] data_block
  input  wire logic [0:0]  in_tuser,   // [0] req_type (1 decrypt)
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] result_block
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);
  import des_pkg::*;

  localparam int NStg = NumRounds + 1;

  // key register
  logic [63:0] key_r;
  logic        key_we;
  rkey_set_t   rkey;

  // stage 0 holds the block after IP; stage n holds it after round n
  logic [31:0]     stg_l_r   [NStg];
  logic [31:0]     stg_rh_r  [NStg];
  logic            stg_dec_r [NStg];
  logic [NStg-1:0] vld_r;
  logic [31:0]     stg_l_nxt [NStg];
  logic [31:0]     stg_rh_nxt [NStg];
  logic [NStg-1:0] stg_rdy;

  logic [63:0] ip_blk;

  // apb: single register, pready tied high
  assign cfg_pready = 1'b1;
  assign key_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[3] == REG_CIPHER_KEY);
  assign cfg_prdata = (cfg_paddr[3] == REG_CIPHER_KEY) ? key_r : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= 64'd0;
    end else if (key_we) begin
      key_r <= cfg_pwdata;
    end
  end

  // round keys are wiring from the key register
  always_comb begin
    for (int i = 0; i < NumRounds; i++) rkey[i] = des_round_key(key_r, i);
  end

  // a stage may load when it is empty or its content moves on
  always_comb begin
    stg_rdy[NStg-1] = !vld_r[NStg-1] || out_tready;
    for (int i = NStg - 2; i >= 0; i--) stg_rdy[i] = !vld_r[i] || stg_rdy[i+1];
  end

  assign in_tready = stg_rdy[0];
  assign ip_blk    = des_ip(in_tdata);

  // one feistel round per stage, key chosen by the request's direction
  always_comb begin
    stg_l_nxt[0]  = ip_blk[63:32];
    stg_rh_nxt[0] = ip_blk[31:0];
    for (int i = 1; i < NStg; i++) begin
      stg_l_nxt[i]  = stg_rh_r[i-1];
      stg_rh_nxt[i] = stg_l_r[i-1] ^
                      des_f(stg_rh_r[i-1],
                            stg_dec_r[i-1] ? rkey[NumRounds-i] : rkey[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stg_rdy[0]) vld_r[0] <= in_tvalid;
      for (int i = 1; i < NStg; i++) begin
        if (stg_rdy[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (stg_rdy[0]) begin
      stg_l_r[0]   <= stg_l_nxt[0];
      stg_rh_r[0]  <= stg_rh_nxt[0];
      stg_dec_r[0] <= in_tuser[0];
    end
    for (int i = 1; i < NStg; i++) begin
      if (stg_rdy[i]) begin
        stg_l_r[i]   <= stg_l_nxt[i];
        stg_rh_r[i]  <= stg_rh_nxt[i];
        stg_dec_r[i] <= stg_dec_r[i-1];
      end
    end
  end

  // r16l16 swap then final permutation
  assign out_tvalid = vld_r[NStg-1];
  assign out_tdata  = des_fp({stg_rh_r[NStg-1], stg_l_r[NStg-1]});

  // an accepted request always lands in the input stage
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted request not captured");

  // input only stalls when every stage is occupied
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&vld_r))
    else $error("input stalled with an empty stage");

  // a block leaving the penultimate stage reaches the last one
  a_tail_move: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NStg-2] && stg_rdy[NStg-1] |=> vld_r[NStg-1])
    else $error("block lost between the last two rounds");

  // a held result keeps its direction flag
  a_hold_dec: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(stg_dec_r[NStg-1]))
    else $error("stalled result changed");

endmodule
`default_nettype wire
